// ===== rtl/core/ddgn_pkg.sv =====
// shared types for the detection decoder: configuration, commands and status
`timescale 1ns / 1ps

package ddgn_pkg;

  // coordinate and score widths
  localparam int unsigned CRN_W   = 16;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CLS_W   = 6;
  localparam int unsigned BOX_W   = 4 * CRN_W;
  localparam int unsigned SC_W    = SCORE_W + CLS_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // corner being mapped, in the order they sit in a box word
  typedef enum logic [1:0] {
    CRN_X1,
    CRN_Y1,
    CRN_X2,
    CRN_Y2
  } ddgn_corner_e;

  typedef struct packed {
    logic [15:0] conf_thr;
    logic [15:0] nms_thr;
    logic [5:0]  class_count;
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [19:0] inv_scale;
    logic [9:0]  pad_left;
    logic [9:0]  pad_top;
  } ddgn_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic         take;
    logic         map_step;
    ddgn_corner_e map_sel;
    logic         scan_start;
    logic         resolve;
    logic         area_load;
    logic         emit_rd;
    logic         emit_load;
    logic         frame_clear;
  } ddgn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_busy;
    logic has_best;
    logic surv_full;
    logic out_take;
    logic out_last;
  } ddgn_sts_t;

endpackage

// ===== rtl/core/ddgn_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ddgn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ddgn_ctrl.sv =====
// sequencing state machine for the detection decoder
`timescale 1ns / 1ps

module ddgn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic                frame_end_i,
  input  ddgn_pkg::ddgn_sts_t sts_i,
  output ddgn_pkg::ddgn_cmd_t cmd_o
);
  import ddgn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP,
    S_MAP_WB,
    S_SCAN_START,
    S_SCAN,
    S_RESOLVE,
    S_AREA,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT,
    S_CLEAR
  } state_e;

  state_e       state_q;
  ddgn_corner_e crn_q;
  logic         take;

  assign in_stall_o = (state_q != S_IDLE);
  assign take       = (state_q == S_IDLE) && in_valid_i;

  // commands decoded from state
  always_comb begin
    cmd_o             = '0;
    cmd_o.take        = take;
    cmd_o.map_step    = (state_q == S_MAP);
    cmd_o.map_sel     = crn_q;
    cmd_o.scan_start  = (state_q == S_SCAN_START);
    cmd_o.resolve     = (state_q == S_RESOLVE);
    cmd_o.area_load   = (state_q == S_AREA);
    cmd_o.emit_rd     = (state_q == S_EMIT_RD);
    cmd_o.emit_load   = (state_q == S_EMIT_LD);
    cmd_o.frame_clear = (state_q == S_CLEAR);
  end

  // state and corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      crn_q   <= CRN_X1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (frame_end_i) begin
              state_q <= S_SCAN_START;
            end else if (!op_i) begin
              state_q <= S_MAP;
              crn_q   <= CRN_X1;
            end
          end
        end
        S_MAP: begin
          crn_q <= ddgn_corner_e'(crn_q + 2'd1);
          if (crn_q == CRN_Y2) begin
            state_q <= S_MAP_WB;
          end
        end
        S_MAP_WB:     state_q <= S_IDLE;
        S_SCAN_START: state_q <= S_SCAN;
        S_SCAN: begin
          if (!sts_i.scan_busy) begin
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (sts_i.has_best && !sts_i.surv_full) begin
            state_q <= S_AREA;
          end else begin
            state_q <= S_EMIT_RD;
          end
        end
        S_AREA:    state_q <= S_SCAN_START;
        S_EMIT_RD: state_q <= S_EMIT_LD;
        S_EMIT_LD: state_q <= S_EMIT_WAIT;
        S_EMIT_WAIT: begin
          if (sts_i.out_take) begin
            state_q <= sts_i.out_last ? S_CLEAR : S_EMIT_RD;
          end
        end
        S_CLEAR: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ddgn_dp.sv =====
// datapath: anchor decode, candidate store, suppression pipeline, result register
`timescale 1ns / 1ps

module ddgn_dp #(
  parameter int unsigned CAND_DEPTH     = 256,
  parameter int unsigned MAX_DETECTIONS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddgn_pkg::ddgn_cfg_t cfg_i,
  input  ddgn_pkg::ddgn_cmd_t cmd_i,
  output ddgn_pkg::ddgn_sts_t sts_o,
  input  logic                op_i,
  input  logic [15:0]         center_x_i,
  input  logic [15:0]         center_y_i,
  input  logic [15:0]         box_w_i,
  input  logic [15:0]         box_h_i,
  input  logic [15:0]         class_score_i,
  input  logic                anchor_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                det_valid_o,
  output logic [5:0]          det_class_o,
  output logic [15:0]         det_score_o,
  output logic [11:0]         det_x_o,
  output logic [11:0]         det_y_o,
  output logic [11:0]         det_width_o,
  output logic [11:0]         det_height_o,
  output logic                det_last_o,
  output logic                cand_overflow_o
);
  import ddgn_pkg::*;

  localparam int unsigned AW     = $clog2(CAND_DEPTH);
  localparam int unsigned CW     = $clog2(CAND_DEPTH + 1);
  localparam int unsigned SAW    = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int unsigned EW     = $clog2(MAX_DETECTIONS + 1);
  localparam int unsigned SURV_W = BOX_W + SC_W;

  // anchor state
  logic [15:0]      box_cx_q, box_cy_q, box_w_q, box_h_q;
  logic [BOX_W-1:0] anchor_box_q;
  logic             anchor_open_q, best_valid_q;
  logic [15:0]      best_score_q;
  logic [5:0]       best_class_q, class_cnt_q;
  logic [CW-1:0]    count_q;
  logic             ovf_q;

  // corner mapping
  logic [15:0]      m_center, m_size, m_lim;
  logic [9:0]       m_pad;
  logic             m_far;
  logic [19:0]      m_v;
  logic [37:0]      map_prod_q;
  logic             map_pos_q, map_vld_q;
  logic [15:0]      map_lim_q;
  ddgn_corner_e     map_sel_q;
  logic [18:0]      map_q;
  logic [15:0]      map_res;

  // score item handling
  logic             score_take, better, last_cls, keep, store, room;
  logic [15:0]      nb_score;
  logic [5:0]       nb_class;

  // store ports
  logic [BOX_W-1:0] rd_box;
  logic [SC_W-1:0]  rd_sc;
  logic             rd_flag;
  logic             flag_we, flag_wd;
  logic [AW-1:0]    flag_waddr;

  // suppression pipeline
  logic             scan_on_q, issue_act, scan_busy;
  logic [CW-1:0]    issue_q;
  logic             rv_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [AW-1:0]    r_idx_q, s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [BOX_W-1:0] s1_box_q, s2_box_q, s3_box_q, s4_box_q;
  logic [SC_W-1:0]  s1_sc_q, s2_sc_q, s3_sc_q, s4_sc_q;
  logic [15:0]      ix1, iy1, ix2, iy2, iw, ih;
  logic [15:0]      s1_iw_q, s1_ih_q, s1_wb_q, s1_hb_q;
  logic [31:0]      s2_inter_q, s2_areab_q, s3_inter_q, s4_inter_q;
  logic [32:0]      s3_uni_q;
  logic [32:0]      s4_plo_q;
  logic [31:0]      s4_phi_q;
  logic [48:0]      lhs, rhs;
  logic             supp, supp_wr, pick;

  // current reference box and best of the pass
  logic [BOX_W-1:0] cur_q, best_box_q;
  logic [SC_W-1:0]  best_sc_q;
  logic [AW-1:0]    best_idx_q;
  logic             has_cur_q, has_best_q;
  logic [31:0]      area_a_q;
  logic [15:0]      cw, ch;

  // survivors and output
  logic [EW-1:0]     emitted_q, ek_q;
  logic              full, keep_surv;
  logic [SURV_W-1:0] surv_rd;
  logic [BOX_W-1:0]  e_box;
  logic [15:0]       e_w, e_h;
  logic              out_valid_q, det_valid_q, det_last_q, det_ovf_q;
  logic [5:0]        det_class_q;
  logic [15:0]       det_score_q;
  logic [11:0]       det_x_q, det_y_q, det_w_q, det_h_q;
  logic              out_take;

  // corner operand select
  always_comb begin
    case (cmd_i.map_sel)
      CRN_X1: begin
        m_center = box_cx_q; m_size = box_w_q; m_pad = cfg_i.pad_left;
        m_lim = {cfg_i.image_width, 4'b0}; m_far = 1'b0;
      end
      CRN_Y1: begin
        m_center = box_cy_q; m_size = box_h_q; m_pad = cfg_i.pad_top;
        m_lim = {cfg_i.image_height, 4'b0}; m_far = 1'b0;
      end
      CRN_X2: begin
        m_center = box_cx_q; m_size = box_w_q; m_pad = cfg_i.pad_left;
        m_lim = {cfg_i.image_width, 4'b0}; m_far = 1'b1;
      end
      default: begin
        m_center = box_cy_q; m_size = box_h_q; m_pad = cfg_i.pad_top;
        m_lim = {cfg_i.image_height, 4'b0}; m_far = 1'b1;
      end
    endcase
    m_v = {3'b0, m_center, 1'b0} - {3'b0, m_pad, 7'b0};
    m_v = m_far ? (m_v + {4'b0, m_size}) : (m_v - {4'b0, m_size});
  end

  // corner saturation after the multiply
  assign map_q   = map_prod_q[37:19];
  assign map_res = !map_pos_q ? 16'd0 :
                   (map_q > {3'b0, map_lim_q}) ? map_lim_q : map_q[15:0];

  // class score tracking
  assign score_take = cmd_i.take && op_i && anchor_open_q;
  assign better     = !best_valid_q || (class_score_i > best_score_q);
  assign nb_score   = better ? class_score_i : best_score_q;
  assign nb_class   = better ? class_cnt_q : best_class_q;
  assign last_cls   = anchor_end_i || (class_cnt_q == cfg_i.class_count - 6'd1);
  assign keep       = score_take && last_cls && (nb_score >= cfg_i.conf_thr);
  assign room       = (count_q != CW'(CAND_DEPTH));
  assign store      = keep && room;

  // overlap geometry against the reference box
  always_comb begin
    ix1 = (cur_q[15:0]  > rd_box[15:0])  ? cur_q[15:0]  : rd_box[15:0];
    iy1 = (cur_q[31:16] > rd_box[31:16]) ? cur_q[31:16] : rd_box[31:16];
    ix2 = (cur_q[47:32] < rd_box[47:32]) ? cur_q[47:32] : rd_box[47:32];
    iy2 = (cur_q[63:48] < rd_box[63:48]) ? cur_q[63:48] : rd_box[63:48];
    iw  = (ix2 > ix1) ? (ix2 - ix1) : 16'd0;
    ih  = (iy2 > iy1) ? (iy2 - iy1) : 16'd0;
  end

  // overlap test without a divide: inter*2^16 > thr*union
  assign lhs  = {1'b0, s4_inter_q, 16'b0};
  assign rhs  = {s4_phi_q, 17'b0} + {16'b0, s4_plo_q};
  assign supp = has_cur_q && (lhs > rhs);
  assign supp_wr = s4_v_q && supp;
  assign pick = s4_v_q && !supp &&
                (!has_best_q || (s4_sc_q[SC_W-1:CLS_W] > best_sc_q[SC_W-1:CLS_W]));

  assign issue_act = scan_on_q && (issue_q < count_q);
  assign scan_busy = issue_act || rv_q || s1_v_q || s2_v_q || s3_v_q || s4_v_q;
  assign full      = (emitted_q == EW'(MAX_DETECTIONS));
  assign keep_surv = cmd_i.resolve && has_best_q && !full;

  assign cw = cur_q[47:32] - cur_q[15:0];
  assign ch = cur_q[63:48] - cur_q[31:16];

  // done-flag write port: cleared on store, set on suppression or survival
  always_comb begin
    flag_we    = store || supp_wr || keep_surv;
    flag_wd    = !store;
    flag_waddr = store ? count_q[AW-1:0] : (supp_wr ? s4_idx_q : best_idx_q);
  end

  ddgn_ram #(.WIDTH(BOX_W), .DEPTH(CAND_DEPTH)) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (anchor_box_q),
    .re_i    (issue_act),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_box)
  );

  ddgn_ram #(.WIDTH(SC_W), .DEPTH(CAND_DEPTH)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({nb_score, nb_class}),
    .re_i    (issue_act),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_sc)
  );

  ddgn_ram #(.WIDTH(1), .DEPTH(CAND_DEPTH)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wd),
    .re_i    (issue_act),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_flag)
  );

  ddgn_ram #(.WIDTH(SURV_W), .DEPTH(MAX_DETECTIONS)) u_surv_ram (
    .clk_i   (clk_i),
    .we_i    (keep_surv),
    .waddr_i (emitted_q[SAW-1:0]),
    .wdata_i ({best_box_q, best_sc_q}),
    .re_i    (cmd_i.emit_rd),
    .raddr_i (ek_q[SAW-1:0]),
    .rdata_o (surv_rd)
  );

  assign e_box = surv_rd[SURV_W-1:SC_W];
  assign e_w   = e_box[47:32] - e_box[15:0];
  assign e_h   = e_box[63:48] - e_box[31:16];

  assign out_take = out_valid_q && !out_stall_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_open_q <= 1'b0;
      best_valid_q  <= 1'b0;
      best_class_q  <= '0;
      class_cnt_q   <= '0;
      count_q       <= '0;
      ovf_q         <= 1'b0;
      map_vld_q     <= 1'b0;
      scan_on_q     <= 1'b0;
      issue_q       <= '0;
      rv_q          <= 1'b0;
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
      s3_v_q        <= 1'b0;
      s4_v_q        <= 1'b0;
      has_best_q    <= 1'b0;
      has_cur_q     <= 1'b0;
      emitted_q     <= '0;
      ek_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      map_vld_q <= cmd_i.map_step;
      // anchor tracking
      if (cmd_i.take && !op_i) begin
        anchor_open_q <= 1'b1;
        best_valid_q  <= 1'b0;
        best_class_q  <= '0;
        class_cnt_q   <= '0;
      end else if (score_take) begin
        best_valid_q <= 1'b1;
        best_class_q <= nb_class;
        class_cnt_q  <= class_cnt_q + 6'd1;
        if (last_cls) begin
          anchor_open_q <= 1'b0;
        end
      end
      if (store) begin
        count_q <= count_q + CW'(1);
      end
      if (keep && !room) begin
        ovf_q <= 1'b1;
      end
      // suppression pass
      if (cmd_i.scan_start) begin
        scan_on_q  <= 1'b1;
        issue_q    <= '0;
        has_best_q <= 1'b0;
      end else if (issue_act) begin
        issue_q <= issue_q + CW'(1);
      end
      rv_q   <= issue_act;
      s1_v_q <= rv_q && !rd_flag;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (pick) begin
        has_best_q <= 1'b1;
      end
      if (cmd_i.resolve) begin
        scan_on_q <= 1'b0;
        if (has_best_q && full) begin
          ovf_q <= 1'b1;
        end
      end
      if (keep_surv) begin
        emitted_q <= emitted_q + EW'(1);
        has_cur_q <= 1'b1;
      end
      // result register
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
        ek_q        <= ek_q + EW'(1);
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.frame_clear) begin
        anchor_open_q <= 1'b0;
        best_valid_q  <= 1'b0;
        best_class_q  <= '0;
        class_cnt_q   <= '0;
        count_q       <= '0;
        ovf_q         <= 1'b0;
        has_cur_q     <= 1'b0;
        emitted_q     <= '0;
        ek_q          <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !op_i) begin
      box_cx_q <= center_x_i;
      box_cy_q <= center_y_i;
      box_w_q  <= box_w_i;
      box_h_q  <= box_h_i;
    end
    if (score_take) begin
      best_score_q <= nb_score;
    end
    // corner multiply, then saturate into the anchor box
    if (cmd_i.map_step) begin
      map_prod_q <= m_v[17:0] * cfg_i.inv_scale;
      map_pos_q  <= !m_v[19] && (m_v != 20'd0);
      map_lim_q  <= m_lim;
      map_sel_q  <= cmd_i.map_sel;
    end
    if (map_vld_q) begin
      case (map_sel_q)
        CRN_X1:  anchor_box_q[15:0]  <= map_res;
        CRN_Y1:  anchor_box_q[31:16] <= map_res;
        CRN_X2:  anchor_box_q[47:32] <= map_res;
        default: anchor_box_q[63:48] <= map_res;
      endcase
    end
    // suppression pipeline stages
    r_idx_q  <= issue_q[AW-1:0];
    s1_idx_q <= r_idx_q;
    s1_box_q <= rd_box;
    s1_sc_q  <= rd_sc;
    s1_iw_q  <= iw;
    s1_ih_q  <= ih;
    s1_wb_q  <= rd_box[47:32] - rd_box[15:0];
    s1_hb_q  <= rd_box[63:48] - rd_box[31:16];
    s2_idx_q   <= s1_idx_q;
    s2_box_q   <= s1_box_q;
    s2_sc_q    <= s1_sc_q;
    s2_inter_q <= s1_iw_q * s1_ih_q;
    s2_areab_q <= s1_wb_q * s1_hb_q;
    s3_idx_q   <= s2_idx_q;
    s3_box_q   <= s2_box_q;
    s3_sc_q    <= s2_sc_q;
    s3_inter_q <= s2_inter_q;
    s3_uni_q   <= {1'b0, area_a_q} + {1'b0, s2_areab_q} - {1'b0, s2_inter_q};
    s4_idx_q   <= s3_idx_q;
    s4_box_q   <= s3_box_q;
    s4_sc_q    <= s3_sc_q;
    s4_inter_q <= s3_inter_q;
    s4_plo_q   <= cfg_i.nms_thr * s3_uni_q[16:0];
    s4_phi_q   <= cfg_i.nms_thr * s3_uni_q[32:17];
    if (pick) begin
      best_idx_q <= s4_idx_q;
      best_box_q <= s4_box_q;
      best_sc_q  <= s4_sc_q;
    end
    if (keep_surv) begin
      cur_q <= best_box_q;
    end
    if (cmd_i.area_load) begin
      area_a_q <= cw * ch;
    end
    // load one result
    if (cmd_i.emit_load) begin
      det_ovf_q <= ovf_q;
      if (emitted_q == '0) begin
        det_valid_q <= 1'b0;
        det_class_q <= '0;
        det_score_q <= '0;
        det_x_q     <= '0;
        det_y_q     <= '0;
        det_w_q     <= '0;
        det_h_q     <= '0;
        det_last_q  <= 1'b1;
      end else begin
        det_valid_q <= 1'b1;
        det_class_q <= surv_rd[CLS_W-1:0];
        det_score_q <= surv_rd[SC_W-1:CLS_W];
        det_x_q     <= e_box[15:4];
        det_y_q     <= e_box[31:20];
        det_w_q     <= e_w[15:4];
        det_h_q     <= e_h[15:4];
        det_last_q  <= (ek_q == emitted_q - EW'(1));
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.scan_busy = scan_busy;
    sts_o.has_best  = has_best_q;
    sts_o.surv_full = full;
    sts_o.out_take  = out_take;
    sts_o.out_last  = det_last_q;
  end

  assign out_valid_o     = out_valid_q;
  assign det_valid_o     = det_valid_q;
  assign det_class_o     = det_class_q;
  assign det_score_o     = det_score_q;
  assign det_x_o         = det_x_q;
  assign det_y_o         = det_y_q;
  assign det_width_o     = det_w_q;
  assign det_height_o    = det_h_q;
  assign det_last_o      = det_last_q;
  assign cand_overflow_o = det_ovf_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> !out_valid_q) else $error("result overwritten");

  // store fill never passes its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAND_DEPTH)) else $error("candidate count out of range");

  // a pass is resolved only once its pipeline has drained
  a_resolve_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resolve |-> !scan_busy) else $error("resolve during scan");

endmodule

// ===== rtl/core/detection_decode_greedy_nms.sv =====
// top level of the greedy nms detection decoder: config registers, controller, datapath
`timescale 1ns / 1ps

// Anchors stream in as one box word followed by up to class_count score items.
// A score item is taken without leaving the idle state; a box word stalls the
// input while its four corners go one after another through a single shared
// 18x20 scaling multiplier and are then written back. On the item that carries
// frame_end the input stalls while suppression runs: each pass reads the whole
// candidate store through its single read port, and there is one pass per
// survivor plus one (at most MAX_DETECTIONS+1 passes). The survivors then
// leave one at a time: each is read from the survivor store and loaded into the
// output register, where it waits until it is taken before the next is read. A
// frame with no survivor yields one result with det_valid low. Configuration
// writes are always ready and take effect at once; write them only while the
// block is idle.
module detection_decode_greedy_nms #(
  parameter int unsigned CAND_DEPTH     = 256,
  parameter int unsigned MAX_DETECTIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op_i,
  input  logic [15:0] center_x_i,
  input  logic [15:0] center_y_i,
  input  logic [15:0] box_w_i,
  input  logic [15:0] box_h_i,
  input  logic [15:0] class_score_i,
  input  logic        anchor_end_i,
  input  logic        frame_end_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        det_valid_o,
  output logic [5:0]  det_class_o,
  output logic [15:0] det_score_o,
  output logic [11:0] det_x_o,
  output logic [11:0] det_y_o,
  output logic [11:0] det_width_o,
  output logic [11:0] det_height_o,
  output logic        det_last_o,
  output logic        cand_overflow_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ddgn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ddgn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ddgn_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_THR,
    CFG_NMS_THR,
    CFG_CLASS_COUNT,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_INV_SCALE,
    CFG_PAD_LEFT,
    CFG_PAD_TOP
  } cfg_idx_e;

  ddgn_cfg_t cfg_q;
  ddgn_cmd_t cmd;
  ddgn_sts_t sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_thr     <= 16'd13107;
      cfg_q.nms_thr      <= 16'd29491;
      cfg_q.class_count  <= 6'd37;
      cfg_q.image_width  <= 12'd640;
      cfg_q.image_height <= 12'd640;
      cfg_q.inv_scale    <= 20'd65536;
      cfg_q.pad_left     <= 10'd0;
      cfg_q.pad_top      <= 10'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CONF_THR:     cfg_q.conf_thr     <= cfg_data_i[15:0];
        CFG_NMS_THR:      cfg_q.nms_thr      <= cfg_data_i[15:0];
        CFG_CLASS_COUNT:  cfg_q.class_count  <= cfg_data_i[5:0];
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[11:0];
        CFG_INV_SCALE:    cfg_q.inv_scale    <= cfg_data_i[19:0];
        CFG_PAD_LEFT:     cfg_q.pad_left     <= cfg_data_i[9:0];
        CFG_PAD_TOP:      cfg_q.pad_top      <= cfg_data_i[9:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  ddgn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op_i),
    .frame_end_i (frame_end_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddgn_dp #(
    .CAND_DEPTH     (CAND_DEPTH),
    .MAX_DETECTIONS (MAX_DETECTIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .box_w_i         (box_w_i),
    .box_h_i         (box_h_i),
    .class_score_i   (class_score_i),
    .anchor_end_i    (anchor_end_i),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .det_valid_o     (det_valid_o),
    .det_class_o     (det_class_o),
    .det_score_o     (det_score_o),
    .det_x_o         (det_x_o),
    .det_y_o         (det_y_o),
    .det_width_o     (det_width_o),
    .det_height_o    (det_height_o),
    .det_last_o      (det_last_o),
    .cand_overflow_o (cand_overflow_o)
  );

endmodule

// ===== tb/sv/detection_decode_greedy_nms_tb.sv =====
// self-checking testbench for the greedy nms detection decoder
`timescale 1ns / 1ps

module detection_decode_greedy_nms_tb;
  import ddgn_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned DET_CAP     = 64;
  localparam int unsigned STALL_LIMIT = 300000;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_THR, REG_NMS_THR, REG_CLASS_COUNT, REG_IMAGE_W,
    REG_IMAGE_H, REG_INV_SCALE, REG_PAD_LEFT, REG_PAD_TOP
  } reg_idx_e;

  // item kinds
  localparam logic OP_BOX   = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] bw;
    logic [15:0] bh;
    logic [15:0] score;
    logic        a_end;
    logic        f_end;
  } anchor_item_t;

  typedef struct packed {
    logic        valid;
    logic [5:0]  cls;
    logic [15:0] score;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic        last;
    logic        ovf;
  } detection_t;

  typedef struct packed {
    anchor_item_t item;
    logic         typed;
    detection_t   det;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op_i = 1'b0;
  logic [15:0] center_x_i = '0, center_y_i = '0, box_w_i = '0, box_h_i = '0;
  logic [15:0] class_score_i = '0;
  logic anchor_end_i = 1'b0, frame_end_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic det_valid_o, det_last_o, cand_overflow_o;
  logic [5:0] det_class_o;
  logic [15:0] det_score_o;
  logic [11:0] det_x_o, det_y_o, det_width_o, det_height_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  detection_decode_greedy_nms dut (.*);

  // shadow configuration and decoder state
  logic [15:0] m_conf, m_nms;
  logic [5:0]  m_classes;
  logic [11:0] m_img_w, m_img_h;
  logic [19:0] m_inv;
  logic [9:0]  m_pad_l, m_pad_t;
  logic [63:0] box_store [STORE_DEPTH];
  logic [21:0] rank_store [STORE_DEPTH];
  int unsigned order [STORE_DEPTH];
  bit          dropped [STORE_DEPTH];
  int unsigned kept_count;
  logic [63:0] open_box;
  int          top_score;
  logic [5:0]  top_class, class_idx;
  bit          store_ovf, anchor_live;

  detection_t expected_dets[$];
  int errors = 0;
  bit quiet = 1'b0;
  int unsigned items_sent = 0;

  function automatic logic [15:0] scale_corner(logic [15:0] c, logic [15:0] sz, bit far_side,
                                               logic [9:0] pad, logic [11:0] lim);
    longint v;
    longint unsigned q, cap;
    v = 2 * longint'(c) - 128 * longint'(pad) + (far_side ? longint'(sz) : -longint'(sz));
    cap = longint'(lim) * 16;
    if (v <= 0) return '0;
    q = (longint'(v) * longint'(m_inv)) >> 19;
    return (q > cap) ? cap[15:0] : q[15:0];
  endfunction

  function automatic bit boxes_clash(logic [63:0] a, logic [63:0] b);
    longint unsigned ix1, iy1, ix2, iy2, iw, ih, inter, area_a, area_b;
    ix1 = (a[15:0] > b[15:0]) ? a[15:0] : b[15:0];
    iy1 = (a[31:16] > b[31:16]) ? a[31:16] : b[31:16];
    ix2 = (a[47:32] < b[47:32]) ? a[47:32] : b[47:32];
    iy2 = (a[63:48] < b[63:48]) ? a[63:48] : b[63:48];
    iw = (ix2 > ix1) ? ix2 - ix1 : 0;
    ih = (iy2 > iy1) ? iy2 - iy1 : 0;
    inter = iw * ih;
    area_a = longint'(a[47:32] - a[15:0]) * longint'(a[63:48] - a[31:16]);
    area_b = longint'(b[47:32] - b[15:0]) * longint'(b[63:48] - b[31:16]);
    return (inter << 16) > longint'(m_nms) * (area_a + area_b - inter);
  endfunction

  function automatic void clear_frame_state();
    for (int i = 0; i < STORE_DEPTH; i++) dropped[i] = 1'b0;
    kept_count = 0;
    store_ovf = 1'b0;
    anchor_live = 1'b0;
    top_score = -1;
    top_class = '0;
    class_idx = '0;
  endfunction

  // sort kept boxes, suppress and queue the surviving detections
  function automatic void suppress_and_emit(output detection_t dets[$]);
    int unsigned j, idx, s, emitted;
    detection_t d;
    emitted = 0;
    dets = {};
    for (int unsigned i = 0; i < kept_count; i++) begin
      s = rank_store[i][21:6];
      j = i;
      while (j > 0 && rank_store[order[j-1]][21:6] < s) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int unsigned i = 0; i < kept_count; i++) begin
      idx = order[i];
      if (!dropped[idx]) begin
        if (emitted >= DET_CAP) begin
          store_ovf = 1'b1;
          break;
        end
        d = '0;
        d.valid = 1'b1;
        d.cls = rank_store[idx][5:0];
        d.score = rank_store[idx][21:6];
        d.x = box_store[idx][15:4];
        d.y = box_store[idx][31:20];
        d.w = 12'((box_store[idx][47:32] - box_store[idx][15:0]) >> 4);
        d.h = 12'((box_store[idx][63:48] - box_store[idx][31:16]) >> 4);
        dets = {dets, d};
        emitted++;
        for (int unsigned k = i + 1; k < kept_count; k++)
          if (!dropped[order[k]] && boxes_clash(box_store[idx], box_store[order[k]]))
            dropped[order[k]] = 1'b1;
      end
    end
    if (emitted == 0) begin
      d = '0;
      dets = {dets, d};
    end
    foreach (dets[i]) dets[i].ovf = store_ovf;
    dets[dets.size()-1].last = 1'b1;
    clear_frame_state();
  endfunction

  // advance the decoder state by one accepted item
  function automatic void predict_item(anchor_item_t it, output detection_t dets[$]);
    bit done;
    dets = {};
    if (it.op == OP_BOX) begin
      open_box = {scale_corner(it.cy, it.bh, 1, m_pad_t, m_img_h),
                  scale_corner(it.cx, it.bw, 1, m_pad_l, m_img_w),
                  scale_corner(it.cy, it.bh, 0, m_pad_t, m_img_h),
                  scale_corner(it.cx, it.bw, 0, m_pad_l, m_img_w)};
      top_score = -1;
      top_class = '0;
      class_idx = '0;
      anchor_live = 1'b1;
    end else if (anchor_live) begin
      done = it.a_end || (class_idx == 6'(m_classes - 6'd1));
      if (int'(it.score) > top_score) begin
        top_score = it.score;
        top_class = class_idx;
      end
      class_idx = class_idx + 6'd1;
      if (done) begin
        anchor_live = 1'b0;
        if (top_score >= int'(m_conf)) begin
          if (kept_count < STORE_DEPTH) begin
            box_store[kept_count] = open_box;
            rank_store[kept_count] = {16'(top_score), top_class};
            kept_count++;
          end else begin
            store_ovf = 1'b1;
          end
        end
      end
    end
    if (it.f_end) suppress_and_emit(dets);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    detection_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got = {det_valid_o, det_class_o, det_score_o, det_x_o, det_y_o,
             det_width_o, det_height_o, det_last_o, cand_overflow_o};
      if (expected_dets.size() == 0) begin
        $display("%0t: unexpected detection %p", $time, got);
        errors++;
      end else begin
        want = expected_dets.pop_front();
        if (got.valid !== want.valid) begin
          $display("%0t: det_valid expected %0d got %0d", $time, want.valid, got.valid);
          errors++;
        end
        if (got.cls !== want.cls) begin
          $display("%0t: det_class expected %0d got %0d", $time, want.cls, got.cls);
          errors++;
        end
        if (got.score !== want.score) begin
          $display("%0t: det_score expected %0d got %0d", $time, want.score, got.score);
          errors++;
        end
        if (got.x !== want.x) begin
          $display("%0t: det_x expected %0d got %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: det_y expected %0d got %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.w !== want.w) begin
          $display("%0t: det_width expected %0d got %0d", $time, want.w, got.w);
          errors++;
        end
        if (got.h !== want.h) begin
          $display("%0t: det_height expected %0d got %0d", $time, want.h, got.h);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: det_last expected %0d got %0d", $time, want.last, got.last);
          errors++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: cand_overflow expected %0d got %0d", $time, want.ovf, got.ovf);
          errors++;
        end
      end
    end
  end

  // output stall in random bursts
  always @(negedge clk_i) begin
    int unsigned burst;
    if (burst > 0) begin
      burst--;
      out_stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(0, 12);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_CONF_THR:    m_conf = value[15:0];
      REG_NMS_THR:     m_nms = value[15:0];
      REG_CLASS_COUNT: m_classes = value[5:0];
      REG_IMAGE_W:     m_img_w = value[11:0];
      REG_IMAGE_H:     m_img_h = value[11:0];
      REG_INV_SCALE:   m_inv = value[19:0];
      REG_PAD_LEFT:    m_pad_l = value[9:0];
      REG_PAD_TOP:     m_pad_t = value[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // send one item, wait for its transaction and record what it should produce
  task automatic send_item(anchor_item_t it, bit typed = 1'b0, detection_t det = '0);
    detection_t dets[$];
    @(negedge clk_i);
    in_valid = 1'b1;
    {op_i, center_x_i, center_y_i, box_w_i, box_h_i, class_score_i,
     anchor_end_i, frame_end_i} = it;
    do @(posedge clk_i); while (in_stall);
    predict_item(it, dets);
    if (typed) expected_dets = {expected_dets, det};
    else expected_dets = {expected_dets, dets};
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_dets.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic anchor_item_t box_word(bit wide);
    anchor_item_t it;
    it = '0;
    it.op = OP_BOX;
    if (wide) begin
      it.cx = $urandom;  it.cy = $urandom;  it.bw = $urandom;  it.bh = $urandom;
    end else begin
      it.cx = $urandom_range(0, 700 * 64);  it.cy = $urandom_range(0, 700 * 64);
      it.bw = $urandom_range(0, 200 * 64);  it.bh = $urandom_range(0, 200 * 64);
    end
    return it;
  endfunction

  // one anchor: a box word, then its scores, with some early ends
  task automatic send_anchor(int unsigned classes, bit f_end);
    anchor_item_t it;
    int unsigned n;
    send_item(box_word($urandom_range(0, 3) == 0));
    n = (classes == 0) ? 64 : classes;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
    for (int unsigned k = 0; k < n; k++) begin
      it = '0;
      it.op = OP_SCORE;
      it.score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65500, 65535))
                                             : 16'($urandom);
      it.a_end = (k == n - 1) ? ($urandom_range(0, 1) == 1) : 1'b0;
      if (k == n - 1 && n != classes) it.a_end = 1'b1;
      it.f_end = f_end && (k == n - 1);
      if (it.f_end && $urandom_range(0, 9) == 0) it.a_end = 1'b0;
      send_item(it);
    end
  endtask

  task automatic send_frame(int unsigned anchors);
    anchor_item_t it;
    for (int unsigned a = 0; a < anchors; a++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = box_word(1'b1);
        it.op = OP_SCORE;
        it.score = $urandom;
        send_item(it);
      end
      send_anchor(m_classes, a == anchors - 1);
    end
    if (anchors == 0) begin
      it = box_word(1'b0);
      it.f_end = 1'b1;
      send_item(it);
    end
  endtask

  task automatic program_all(int unsigned conf, int unsigned nms, int unsigned classes,
                             int unsigned w, int unsigned h, int unsigned inv,
                             int unsigned pl, int unsigned pt);
    write_reg(REG_CONF_THR, conf);
    write_reg(REG_NMS_THR, nms);
    write_reg(REG_CLASS_COUNT, classes);
    write_reg(REG_IMAGE_W, w);
    write_reg(REG_IMAGE_H, h);
    write_reg(REG_INV_SCALE, inv);
    write_reg(REG_PAD_LEFT, pl);
    write_reg(REG_PAD_TOP, pt);
  endtask

  // directed rows, run under the reset configuration
  stim_row_t directed [] = '{
    // frame end on a stray score: empty frame
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 1'b1, 1'b1}, 1'b1,
      '{1'b0, 6'd0, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{'{OP_BOX, 16'd20480, 16'd20480, 16'd4096, 16'd4096, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
    // score after the anchor closed is ignored
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_BOX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_BOX, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd20000, 1'b0, 1'b0}, 1'b0, '0},
    // new box word abandons the open anchor
    '{'{OP_BOX, 16'd6400, 16'd9000, 16'd3000, 16'd2500, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd13107, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_BOX, 16'd20600, 16'd20400, 16'd4000, 16'd4100, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd13106, 1'b1, 1'b0}, 1'b0, '0},
    // frame end on a box word abandons it
    '{'{OP_BOX, 16'd100, 16'd200, 16'd300, 16'd400, 16'd0, 1'b0, 1'b1}, 1'b0, '0},
    // frame end mid-anchor abandons it: empty frame
    '{'{OP_BOX, 16'd20480, 16'd20480, 16'd4096, 16'd4096, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd40000, 1'b0, 1'b1}, 1'b1,
      '{1'b0, 6'd0, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0}}
  };

  initial begin
    m_conf = 16'd13107;  m_nms = 16'd29491;  m_classes = 6'd37;
    m_img_w = 12'd640;   m_img_h = 12'd640;  m_inv = 20'd65536;
    m_pad_l = '0;        m_pad_t = '0;       open_box = '0;
    clear_frame_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].det);
    settle();

    // low extremes, then high extremes with a full-length anchor
    program_all(0, 0, 1, 1, 1, 0, 0, 0);
    send_frame(4);
    send_frame(0);
    settle();
    program_all(65535, 65535, 63, 4095, 4095, 20'hFFFFF, 640, 640);
    write_reg(REG_CLASS_COUNT, 0);
    send_frame(1);
    settle();

    // detection overflow: more kept anchors than the result cap
    program_all(0, 65535, 1, 4095, 4095, 65536, 0, 0);
    for (int unsigned a = 0; a < DET_CAP + 4; a++) begin
      send_item(box_word(1'b0));
      send_item('{OP_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'($urandom),
                  1'b1, a == DET_CAP + 3});
    end
    settle();

    // random phases under random settings
    while (items_sent < 255) begin
      quiet = (items_sent > 230);
      program_all($urandom_range(0, 45000), $urandom, $urandom_range(1, 6),
                  $urandom_range(1, 4095), $urandom_range(1, 4095),
                  $urandom_range(20000, 200000), $urandom_range(0, 640),
                  $urandom_range(0, 640));
      repeat ($urandom_range(1, 2)) send_frame($urandom_range(0, 5));
      settle();
    end

    if (errors == 0 && expected_dets.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
